### rtl/inv3_pkg.sv
// Package with the word types and fixed widths of the 3x3 matrix inverse.
`timescale 1ns / 1ps
package inv3_pkg;

  localparam int ELEM_WIDTH = 16;
  localparam int OUT_WIDTH  = 32;
  // Q8.24 adjugate scaled to Q16.16 against a Q12.36 determinant.
  localparam int FRAC_SHIFT = 28;
  localparam int PROD_W     = 2 * ELEM_WIDTH;
  localparam int ADJ_W      = 2 * ELEM_WIDTH + 1;
  localparam int DPROD_W    = 3 * ELEM_WIDTH + 1;
  localparam int DET_W      = 3 * ELEM_WIDTH + 3;
  localparam int AMAG_W     = 2 * ELEM_WIDTH;
  localparam int DIV_W      = DET_W;
  localparam int QUO_W      = AMAG_W + FRAC_SHIFT;
  localparam int NLANES     = 9;
  localparam int THR_W      = 32;
  localparam logic [1:0] ADDR_THRESH = 2'd0;

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [OUT_WIDTH-1:0]  oelem_t;

  typedef struct packed {
    elem_t m_r0c0;
    elem_t m_r0c1;
    elem_t m_r0c2;
    elem_t m_r1c0;
    elem_t m_r1c1;
    elem_t m_r1c2;
    elem_t m_r2c0;
    elem_t m_r2c1;
    elem_t m_r2c2;
  } in_t;

  typedef struct packed {
    oelem_t inv_r0c0;
    oelem_t inv_r0c1;
    oelem_t inv_r0c2;
    oelem_t inv_r1c0;
    oelem_t inv_r1c1;
    oelem_t inv_r1c2;
    oelem_t inv_r2c0;
    oelem_t inv_r2c1;
    oelem_t inv_r2c2;
    logic   near_singular;
    logic   saturated;
  } out_t;

  typedef struct packed {
    logic valid;
    logic zero;
    logic near;
  } ctl_t;

endpackage

### rtl/inv3_front.sv
// Cofactor and determinant pipeline that feeds the divider lanes.
`timescale 1ns / 1ps
module inv3_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   valid_i,
  input  inv3_pkg::in_t                          data_i,
  input  logic [inv3_pkg::THR_W-1:0]             thr_i,
  output logic [8:0][inv3_pkg::AMAG_W-1:0]       dvd_o,
  output logic [8:0]                             neg_o,
  output logic [inv3_pkg::DIV_W-1:0]             div_o,
  output inv3_pkg::ctl_t                         ctl_o
);
  import inv3_pkg::*;

  elem_t                    a [9];
  logic signed [PROD_W-1:0] p_r [18];
  elem_t                    a1_r [3];
  elem_t                    a2_r [3];
  logic signed [ADJ_W-1:0]  adj_r [9];
  logic signed [ADJ_W-1:0]  adj3_r [9];
  logic signed [DPROD_W-1:0] dp_r [3];
  logic [2:0]               v_r;
  logic signed [DET_W-1:0]  dpx [3];
  logic signed [DET_W-1:0]  det;
  logic signed [DET_W-1:0]  det_neg;
  logic [DIV_W-1:0]         det_mag;
  logic signed [ADJ_W-1:0]  adj_neg [9];
  logic [8:0][AMAG_W-1:0]   dvd_nxt;
  logic [8:0]               neg_nxt;

  always_comb begin
    a[0] = data_i.m_r0c0; a[1] = data_i.m_r0c1; a[2] = data_i.m_r0c2;
    a[3] = data_i.m_r1c0; a[4] = data_i.m_r1c1; a[5] = data_i.m_r1c2;
    a[6] = data_i.m_r2c0; a[7] = data_i.m_r2c1; a[8] = data_i.m_r2c2;
  end

  // Each cofactor is the difference of two products taken in this order.
  always_ff @(posedge clk) begin
    p_r[0]  <= a[4] * a[8]; p_r[1]  <= a[7] * a[5];
    p_r[2]  <= a[7] * a[2]; p_r[3]  <= a[1] * a[8];
    p_r[4]  <= a[1] * a[5]; p_r[5]  <= a[4] * a[2];
    p_r[6]  <= a[5] * a[6]; p_r[7]  <= a[8] * a[3];
    p_r[8]  <= a[8] * a[0]; p_r[9]  <= a[2] * a[6];
    p_r[10] <= a[2] * a[3]; p_r[11] <= a[5] * a[0];
    p_r[12] <= a[3] * a[7]; p_r[13] <= a[6] * a[4];
    p_r[14] <= a[6] * a[1]; p_r[15] <= a[0] * a[7];
    p_r[16] <= a[0] * a[4]; p_r[17] <= a[3] * a[1];
    a1_r[0] <= a[0]; a1_r[1] <= a[1]; a1_r[2] <= a[2];
    a2_r    <= a1_r;
    for (int k = 0; k < 9; k++) begin
      adj_r[k] <= ADJ_W'(p_r[2*k]) - ADJ_W'(p_r[2*k+1]);
    end
    adj3_r   <= adj_r;
    dp_r[0]  <= a2_r[0] * adj_r[0];
    dp_r[1]  <= a2_r[1] * adj_r[3];
    dp_r[2]  <= a2_r[2] * adj_r[6];
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dpx[j] = DET_W'(dp_r[j]);
    end
    det     = dpx[0] + dpx[1] + dpx[2];
    det_neg = -det;
    det_mag = det[DET_W-1] ? det_neg : det;
    for (int k = 0; k < 9; k++) begin
      adj_neg[k] = -adj3_r[k];
      dvd_nxt[k] = adj3_r[k][ADJ_W-1] ? adj_neg[k][AMAG_W-1:0] : adj3_r[k][AMAG_W-1:0];
      neg_nxt[k] = adj3_r[k][ADJ_W-1] ^ det[DET_W-1];
    end
  end

  always_ff @(posedge clk) begin
    dvd_o      <= dvd_nxt;
    neg_o      <= neg_nxt;
    div_o      <= det_mag;
    ctl_o.zero <= (det == '0);
    ctl_o.near <= (det_mag < DIV_W'(thr_i));
    if (!rst_n) begin
      v_r         <= '0;
      ctl_o.valid <= 1'b0;
    end else begin
      v_r         <= {v_r[1:0], valid_i};
      ctl_o.valid <= v_r[2];
    end
  end

endmodule

### rtl/inv3_lane.sv
// One divider lane: restoring division, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
module inv3_lane (
  input  logic                              clk,
  input  logic [inv3_pkg::AMAG_W-1:0]       dvd_i,
  input  logic [inv3_pkg::DIV_W-1:0]        div_i,
  input  logic                              neg_i,
  output logic [inv3_pkg::QUO_W-1:0]        quo_o,
  output logic                              neg_o
);
  import inv3_pkg::*;

  logic [DIV_W-1:0] rem_r [1:QUO_W];
  logic [QUO_W-1:0] num_r [1:QUO_W];
  logic [DIV_W-1:0] div_r [1:QUO_W];
  logic             neg_r [1:QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [DIV_W-1:0] rem_in;
    logic [QUO_W-1:0] num_in;
    logic [DIV_W-1:0] div_in;
    logic             neg_in;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    if (s == 0) begin : g_first
      // The dividend is the adjugate magnitude shifted up by the fraction shift.
      assign rem_in = '0;
      assign num_in = {dvd_i, {FRAC_SHIFT{1'b0}}};
      assign div_in = div_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_r[s];
      assign num_in = num_r[s];
      assign div_in = div_r[s];
      assign neg_in = neg_r[s];
    end

    assign trial = {rem_in, num_in[QUO_W-1]};
    assign diff  = trial - {1'b0, div_in};
    assign ge    = (trial >= {1'b0, div_in});

    always_ff @(posedge clk) begin
      rem_r[s+1] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      num_r[s+1] <= {num_in[QUO_W-2:0], ge};
      div_r[s+1] <= div_in;
      neg_r[s+1] <= neg_in;
    end
  end

  assign quo_o = num_r[QUO_W];
  assign neg_o = neg_r[QUO_W];

endmodule

### rtl/inv3_merge.sv
// Merge stage: signs and saturates the nine quotients into the result word.
`timescale 1ns / 1ps
module inv3_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [8:0][inv3_pkg::QUO_W-1:0]   quo_i,
  input  logic [8:0]                        neg_i,
  input  inv3_pkg::ctl_t                    ctl_i,
  output logic                              out_valid,
  output inv3_pkg::out_t                    out_data
);
  import inv3_pkg::*;

  localparam int CW = ((QUO_W > OUT_WIDTH) ? QUO_W : OUT_WIDTH) + 1;
  localparam logic [CW-1:0] NEG_MAX = CW'(1) << (OUT_WIDTH - 1);
  localparam logic [CW-1:0] POS_MAX = NEG_MAX - CW'(1);

  logic [CW-1:0]  qx [9];
  logic [CW-1:0]  lim [9];
  logic [CW-1:0]  v [9];
  logic [CW-1:0]  nv [9];
  logic [8:0]     clip;
  oelem_t         res [9];
  out_t           out_nxt;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      qx[k]   = CW'(quo_i[k]);
      lim[k]  = neg_i[k] ? NEG_MAX : POS_MAX;
      clip[k] = !ctl_i.zero && (qx[k] > lim[k]);
      v[k]    = (qx[k] > lim[k]) ? lim[k] : qx[k];
      nv[k]   = CW'(0) - v[k];
      if (ctl_i.zero) begin
        res[k] = '0;
      end else begin
        res[k] = neg_i[k] ? nv[k][OUT_WIDTH-1:0] : v[k][OUT_WIDTH-1:0];
      end
    end
    out_nxt.inv_r0c0      = res[0];
    out_nxt.inv_r0c1      = res[1];
    out_nxt.inv_r0c2      = res[2];
    out_nxt.inv_r1c0      = res[3];
    out_nxt.inv_r1c1      = res[4];
    out_nxt.inv_r1c2      = res[5];
    out_nxt.inv_r2c0      = res[6];
    out_nxt.inv_r2c1      = res[7];
    out_nxt.inv_r2c2      = res[8];
    out_nxt.near_singular = ctl_i.near;
    out_nxt.saturated     = |clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_zero_det: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_i.valid && ctl_i.zero |=> out_valid && !out_data.saturated &&
      out_data.inv_r0c0 == '0 && out_data.inv_r1c1 == '0 && out_data.inv_r2c2 == '0)
    else $error("zero determinant gave a nonzero result word");
  a_valid_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(ctl_i.valid))
    else $error("result strobe without a word in the last divider stage");
  a_zero_near: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_i.valid && ctl_i.zero && ctl_i.near |=> out_data.near_singular)
    else $error("near singular flag lost at merge");
`endif

endmodule

### rtl/matrix3x3_inverse.sv
// Top level of the 3x3 fixed-point matrix inverse by the adjugate.
//
//  port group   direction  handshake                 word
//  start/in_    in         start && !busy            in_data (nine Q4.12)
//  out_         out        out_valid strobe          out_data (nine Q16.16, flags)
//  p*           in/out     psel, penable, pwrite     singular_threshold at 0x0
//
// One matrix is taken every cycle; busy never rises.
// A word passes through the products, cofactors and determinant, then the bit-per-stage
// divider lanes (one per result entry), and last the merge stage.
// Reset clears the valid pipeline and sets singular_threshold to 1.
// The receiver cannot stall, so each result word appears for exactly one cycle.
`timescale 1ns / 1ps
module matrix3x3_inverse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  inv3_pkg::in_t         in_data,
  output logic                  out_valid,
  output inv3_pkg::out_t        out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import inv3_pkg::*;

  logic [THR_W-1:0]         thr_r;
  logic                     wr_en;
  logic [8:0][AMAG_W-1:0]   dvd;
  logic [8:0]               neg;
  logic [DIV_W-1:0]         div;
  ctl_t                     ctl_f;
  ctl_t                     ctl_r [1:QUO_W];
  logic [8:0][QUO_W-1:0]    quo;
  logic [8:0]               qneg;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = thr_r;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_THRESH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(1);
    end else if (wr_en) begin
      thr_r <= pwdata;
    end
  end

  inv3_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start && !busy),
    .data_i  (in_data),
    .thr_i   (thr_r),
    .dvd_o   (dvd),
    .neg_o   (neg),
    .div_o   (div),
    .ctl_o   (ctl_f)
  );

  for (genvar k = 0; k < NLANES; k++) begin : g_lane
    inv3_lane u_lane (
      .clk   (clk),
      .dvd_i (dvd[k]),
      .div_i (div),
      .neg_i (neg[k]),
      .quo_o (quo[k]),
      .neg_o (qneg[k])
    );
  end

  // Sideband flags ride alongside the divider lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= QUO_W; s++) begin
        ctl_r[s] <= '0;
      end
    end else begin
      ctl_r[1] <= ctl_f;
      for (int s = 2; s <= QUO_W; s++) begin
        ctl_r[s] <= ctl_r[s-1];
      end
    end
  end

  inv3_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .quo_i     (quo),
    .neg_i     (qneg),
    .ctl_i     (ctl_r[QUO_W]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_thr_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> thr_r == $past(pwdata))
    else $error("threshold write was lost");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_f.valid |-> ##(QUO_W + 1) out_valid)
    else $error("word lost between front end and result strobe");
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("start was refused");
`endif

endmodule

### tb/inv3_checker.sv
// Checker that predicts and compares every result word of the 3x3 matrix inverse.
`timescale 1ns / 1ps
module inv3_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  inv3_pkg::in_t  in_data,
  input  logic           out_valid,
  input  inv3_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [1:0]     paddr,
  input  logic [31:0]    pwdata,
  input  logic           pready,
  output int             fail_count,
  output int             pending
);
  import inv3_pkg::*;

  localparam int OUT_BITS = $bits(out_t);

  out_t        inverse_q[$];
  logic [31:0] threshold;
  string       lane_name[9] = '{"inv_r0c0", "inv_r0c1", "inv_r0c2", "inv_r1c0", "inv_r1c1",
                                "inv_r1c2", "inv_r2c0", "inv_r2c1", "inv_r2c2"};

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Truncating quotient in Q16.16, clipped to the 32-bit signed range.
  function automatic logic [31:0] scaled_quotient(longint adj, longint det, ref logic clip);
    longint unsigned q;
    logic            neg;
    neg = (adj < 0) != (det < 0);
    q = (magnitude(adj) << FRAC_SHIFT) / magnitude(det);
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) begin
        clip = 1'b1;
        q = 64'h7FFF_FFFF;
      end
      return q[31:0];
    end
    if (q > 64'h8000_0000) begin
      clip = 1'b1;
      q = 64'h8000_0000;
    end
    return 32'(-q);
  endfunction

  function automatic out_t invert(in_t m, logic [31:0] thr);
    longint                a[9];
    longint                adj[9];
    longint                det;
    logic                  clip;
    logic [OUT_BITS-1:0]   bits;
    clip = 1'b0;
    for (int i = 0; i < 9; i++) a[i] = longint'($signed(m[143-16*i -: 16]));
    adj[0] = a[4]*a[8] - a[7]*a[5];
    adj[1] = a[7]*a[2] - a[1]*a[8];
    adj[2] = a[1]*a[5] - a[4]*a[2];
    adj[3] = a[5]*a[6] - a[8]*a[3];
    adj[4] = a[8]*a[0] - a[2]*a[6];
    adj[5] = a[2]*a[3] - a[5]*a[0];
    adj[6] = a[3]*a[7] - a[6]*a[4];
    adj[7] = a[6]*a[1] - a[0]*a[7];
    adj[8] = a[0]*a[4] - a[3]*a[1];
    det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
    bits = '0;
    for (int i = 0; i < 9; i++)
      bits[OUT_BITS-1-32*i -: 32] = (det == 0) ? 32'd0 : scaled_quotient(adj[i], det, clip);
    bits[1] = magnitude(det) < 64'(thr);
    bits[0] = clip;
    return out_t'(bits);
  endfunction

  assign pending = inverse_q.size();

  always @(posedge clk) begin
    out_t exp_w;
    if (!rst_n) begin
      threshold <= 32'd1;
      inverse_q.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_THRESH) threshold <= pwdata;
      if (start && !busy) inverse_q.push_back(invert(in_data, threshold));
      if (out_valid) begin
        if (inverse_q.size() == 0) begin
          $error("result word with no expectation waiting: %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = inverse_q.pop_front();
          if (exp_w != out_data) begin
            for (int i = 0; i < 9; i++)
              if (exp_w[OUT_BITS-1-32*i -: 32] != out_data[OUT_BITS-1-32*i -: 32])
                $error("%s expected %0d actual %0d", lane_name[i],
                       $signed(exp_w[OUT_BITS-1-32*i -: 32]),
                       $signed(out_data[OUT_BITS-1-32*i -: 32]));
            if (exp_w.near_singular != out_data.near_singular)
              $error("near_singular expected %0b actual %0b", exp_w.near_singular,
                     out_data.near_singular);
            if (exp_w.saturated != out_data.saturated)
              $error("saturated expected %0b actual %0b", exp_w.saturated, out_data.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### tb/testbench.sv
// Top of the testbench: clock, reset, matrix and threshold stimulus, and the verdict.
`timescale 1ns / 1ps
module testbench;
  import inv3_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_data;
  logic        out_valid;
  out_t        out_data;
  logic        psel, penable, pwrite, pready;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending;
  bit          idle_on;

  matrix3x3_inverse uut (.*);

  inv3_checker chk (.*);

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  initial begin
    #(12 * 400000);
    $display("FAILURE");
    $finish;
  end

  function automatic elem_t rand_elem();
    int r;
    r = $urandom_range(99);
    if (r < 40) return elem_t'($urandom);
    if (r < 75) return elem_t'($urandom_range(8192) - 4096);
    case ($urandom_range(5))
      0: return 16'sd0;
      1: return 16'sh7FFF;
      2: return 16'sh8000;
      3: return 16'sd4096;
      4: return -16'sd4096;
      default: return elem_t'($urandom_range(7) - 3);
    endcase
  endfunction

  function automatic in_t rand_matrix();
    in_t m;
    m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
         rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    // Some get a repeated row or column (zero determinant) or r2c2 bit 0 flipped.
    case ($urandom_range(9))
      0: m[47:0] = m[143:96];
      1: begin
        m.m_r0c2 = m.m_r0c0; m.m_r1c2 = m.m_r1c0; m.m_r2c2 = m.m_r2c0;
      end
      2: m.m_r2c2 = m.m_r2c2 ^ elem_t'($urandom_range(1));
      default: ;
    endcase
    return m;
  endfunction

  task automatic send_word(in_t m);
    while (idle_on && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= m;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_THRESH;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    in_t         m;
    logic [31:0] thr_set[4];
    start = 1'b0; in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    idle_on = 1'b1;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed matrices under the reset threshold.
    send_word('0);
    send_word({16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd4096});
    send_word({16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sh8000});
    send_word({16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF});
    send_word({9{16'sh7FFF}});
    send_word({9{16'sh8000}});
    send_word({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1});
    send_word({16'sh7FFF, 16'sh8000, 16'sd0, 16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0,
               16'sd1});
    send_word({-16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd1});
    send_word({16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
               16'sh7FFF, 16'sh7FFF});
    send_word({16'sd4096, 16'sd8192, 16'sd12288, 16'sd4096, 16'sd8192, 16'sd12288,
               16'sd1, 16'sd2, 16'sd4});
    send_word({16'sd0, 16'sd4096, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
               -16'sd4096});
    send_word({16'sd2, 16'sd1, 16'sd0, 16'sd1, 16'sd2, 16'sd1, 16'sd0, 16'sd1, 16'sd2});
    drain();

    // Threshold extremes plus a random one, then back to one; each phase also
    // acts as a pause until every expected word has come.
    thr_set = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd1};
    for (int p = 0; p < 4; p++) begin
      write_threshold(thr_set[p]);
      send_word('0);
      send_word({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1});
      idle_on = (p != 2);
      for (int i = 0; i < 150; i++) begin
        m = rand_matrix();
        send_word(m);
      end
      idle_on = 1'b1;
      drain();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
